// ----- sv/iir_direct_form1_filter_core_assert.svh -----
// Assertion macros for the IIR direct-form-I filter core.
// Used by the top level; no other dependencies.
`ifndef IIR_DIRECT_FORM1_FILTER_CORE_ASSERT_SVH
`define IIR_DIRECT_FORM1_FILTER_CORE_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define IIRDF1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define IIRDF1_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/iirdf1_pkg.sv -----
// Shared types and constants of the IIR direct-form-I filter core.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package iirdf1_pkg;

  localparam int unsigned DEFAULT_ORDER = 3;
  localparam int unsigned COEF_TAPS     = 3;   // taps that carry coefficients
  localparam int unsigned NUM_COEF      = 7;
  localparam int unsigned COEF_W        = 24;  // Q3.20
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned HIST_W        = 26;  // Q17.8
  localparam int unsigned PROD_W        = COEF_W + HIST_W;
  localparam int unsigned ACC_W         = 54;
  localparam int unsigned APB_AW        = 5;

  // Coefficient register indexes
  localparam logic [2:0] CIDX_B0     = 3'd0;
  localparam logic [2:0] CIDX_A_BASE = 3'd3;

  // Operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    24'sd3039, 24'sd9117, 24'sd9117, 24'sd3039,
    -24'sd2489419, 24'sd2023076, -24'sd557921
  };

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROUND = 5'b01000,
    S_WB    = 5'b10000
  } state_e;

endpackage

// ----- sv/iir_direct_form1_filter_core.sv -----
// IIR direct-form-I low-pass filter core (default third order, Q3.20 coefficients).
// Depends on iirdf1_pkg, iirdf1_ram and iir_direct_form1_filter_core_assert.svh.
//
// Each input beat either filters one signed 16-bit sample (tuser = 0) or clears
// the filter (tuser = 1). Every beat yields exactly one output beat holding the
// filtered sample rounded and saturated to 16 bits, a saturation flag and a
// history-filled flag. Sample and output history sit together in one RAM used
// as a circular delay line of ORDER entries; one shared 24x26 multiplier walks
// the taps b0*x, then b_k*x[n-k] and a_k*y[n-k] for k = 1..min(ORDER,3), one
// product a cycle, while the RAM read for the next tap is in flight. The core
// takes no new beat until the previous one is written back: a filter beat runs
// the multiply-accumulate loop, a clear beat goes straight to write-back.
// Input is accepted while a finished result still waits on the output
// register; the write-back stalls only if a second result is ready before
// the first is taken. Clearing drops per-entry valid bits, so an entry not
// written since reset or clear reads as zero; no RAM sweep is needed.
// Coefficients are written over the APB port at byte address 4*i; write them
// only while the core is idle, which the core itself does not enforce.
`timescale 1ns / 1ps

`include "iir_direct_form1_filter_core_assert.svh"

module iir_direct_form1_filter_core
  import iirdf1_pkg::*;
#(
  parameter int unsigned ORDER = DEFAULT_ORDER
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [15:0]       s_axis_tdata_i,   // [15:0] sample
  input  logic              s_axis_tuser_i,   // [0] operation
  // output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,   // [15:0] filtered, [16] saturated,
                                              // [17] history_filled, [23:18] zero
  // configuration
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  localparam int unsigned NTAP   = (ORDER < COEF_TAPS) ? ORDER : COEF_TAPS;
  localparam int unsigned PTR_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int unsigned FILL_W = $clog2(ORDER + 1);
  localparam int unsigned RAM_W  = HIST_W + SAMPLE_W;
  localparam logic [2:0]  LAST_STEP = 3'(2 * NTAP);
  localparam logic [4:0]  ORD5      = 5'(ORDER);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ORDER);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_q [NUM_COEF];
  logic [2:0]               cfg_idx;
  logic                     cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_idx  = paddr_i[4:2];
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= COEF_RESET[i];
    end else if (cfg_wr && (32'(cfg_idx) < NUM_COEF)) begin
      coef_q[cfg_idx] <= pwdata_i[COEF_W-1:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (32'(cfg_idx) < NUM_COEF) begin
      prdata_o = {{(32-COEF_W){coef_q[cfg_idx][COEF_W-1]}}, coef_q[cfg_idx]};
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [2:0]          step_q, step_d;
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [ORDER-1:0]    vld_q, vld_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                clr_q, clr_d;
  logic                pvld_q, pvld_d;
  logic                sub_q, sub_d;
  logic                rvld_q, rvld_d;
  logic                out_vld_q, out_vld_d;

  // payload registers
  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [HIST_W-1:0]   y_q, y_d;
  logic [23:0]                out_q, out_d;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   raddr;
  logic [RAM_W-1:0]   rdata;
  logic [1:0]         tap;
  logic [4:0]         addr_sum;
  logic [2:0]         cidx;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [HIST_W-1:0] opnd_sel;
  logic signed [SAMPLE_W-1:0] xh;
  logic signed [HIST_W-1:0]   yh;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-21:0]   y_full;
  logic signed [HIST_W:0]     y_rnd;
  logic signed [HIST_W-8:0]   r_full;
  logic signed [SAMPLE_W-1:0] r_sat;
  logic                       r_ovf;
  logic                       filled_next;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // Tap k reads slot (wptr - k) mod ORDER; wptr is the oldest entry.
  assign tap      = step_q[2:1] + 2'd1;
  assign addr_sum = 5'(wptr_q) + ORD5 - 5'(tap);
  assign raddr    = (addr_sum >= ORD5) ? PTR_W'(addr_sum - ORD5) : PTR_W'(addr_sum);
  assign ram_re   = (state_q == S_MAC) && !step_q[0] && (step_q != LAST_STEP);

  // History operands; an entry not written since clear reads as zero.
  assign xh = rvld_q ? signed'(rdata[SAMPLE_W-1:0]) : '0;
  assign yh = rvld_q ? signed'(rdata[RAM_W-1:SAMPLE_W]) : '0;

  // Coefficient and operand select for the current step.
  always_comb begin
    if (step_q == 3'd0) begin
      cidx     = CIDX_B0;
      opnd_sel = {{(HIST_W-SAMPLE_W-8){x_q[SAMPLE_W-1]}}, x_q, 8'd0};
    end else if (step_q[0]) begin
      cidx     = (step_q + 3'd1) >> 1;
      opnd_sel = {{(HIST_W-SAMPLE_W-8){xh[SAMPLE_W-1]}}, xh, 8'd0};
    end else begin
      cidx     = CIDX_A_BASE + (step_q >> 1);
      opnd_sel = yh;
    end
    coef_sel = coef_q[cidx];
  end

  // Round to Q.8 and saturate to the history width.
  assign rnd    = acc_q + ACC_W'(1 << 19);
  assign y_full = rnd[ACC_W-1:20];
  always_comb begin
    if (y_full > (ACC_W-20)'(signed'((1 << (HIST_W-1)) - 1))) begin
      y_d = {1'b0, {(HIST_W-1){1'b1}}};
    end else if (y_full < -(ACC_W-20)'(signed'(1 << (HIST_W-1)))) begin
      y_d = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      y_d = y_full[HIST_W-1:0];
    end
  end

  // Round to an integer sample and saturate to 16 bits.
  assign y_rnd  = {y_q[HIST_W-1], y_q} + (HIST_W+1)'(128);
  assign r_full = y_rnd[HIST_W:8];
  always_comb begin
    r_ovf = 1'b1;
    if (r_full > (HIST_W-7)'(32767)) begin
      r_sat = 16'sh7fff;
    end else if (r_full < -(HIST_W-7)'(32768)) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = r_full[SAMPLE_W-1:0];
      r_ovf = 1'b0;
    end
  end

  assign prod_d = coef_sel * opnd_sel;
  assign sub_d  = (step_q != 3'd0) && !step_q[0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    wptr_d    = wptr_q;
    vld_d     = vld_q;
    fill_d    = fill_q;
    clr_d     = clr_q;
    pvld_d    = 1'b0;
    rvld_d    = rvld_q;
    out_vld_d = out_vld_q;
    x_d       = x_q;
    acc_d     = acc_q;
    out_d     = out_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    filled_next = 1'b0;

    if (out_vld_q && m_axis_tready_i) out_vld_d = 1'b0;
    if (ram_re) rvld_d = vld_q[raddr];
    // accumulate the product registered in the previous cycle
    if (pvld_q) acc_d = sub_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_d    = s_axis_tdata_i;
          clr_d  = (s_axis_tuser_i == OP_CLEAR);
          step_d = '0;
          acc_d  = '0;
          state_d = (s_axis_tuser_i == OP_CLEAR) ? S_WB : S_MAC;
        end
      end
      S_MAC: begin
        pvld_d = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_DRAIN: begin
        state_d = S_ROUND;
      end
      S_ROUND: begin
        state_d = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (clr_q) begin
            vld_d  = '0;
            fill_d = FILL_ONE;
            filled_next = (FILL_ONE == FILL_MAX);
            out_d  = {6'd0, filled_next, 1'b0, 16'd0};
          end else begin
            ram_we = 1'b1;
            vld_d[wptr_q] = 1'b1;
            wptr_d = (32'(wptr_q) == ORDER - 1) ? '0 : wptr_q + PTR_W'(1);
            if (fill_q != FILL_MAX) fill_d = fill_q + FILL_W'(1);
            filled_next = (fill_d == FILL_MAX);
            out_d  = {6'd0, filled_next, r_ovf, r_sat};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      wptr_q    <= '0;
      vld_q     <= '0;
      fill_q    <= FILL_ONE;
      clr_q     <= 1'b0;
      pvld_q    <= 1'b0;
      sub_q     <= 1'b0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      wptr_q    <= wptr_d;
      vld_q     <= vld_d;
      fill_q    <= fill_d;
      clr_q     <= clr_d;
      pvld_q    <= pvld_d;
      sub_q     <= sub_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (state_q == S_ROUND) y_q <= y_d;
    out_q  <= out_d;
  end

  // ---------------------------------------------------------------------------
  // History RAM: {y (Q17.8), x} per slot
  // ---------------------------------------------------------------------------
  iirdf1_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ORDER)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i ({y_q, x_q}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IIRDF1_ASSERT_NEVER(a_no_rw_overlap, ram_we && ram_re,
    "history RAM read and write in the same cycle")
  `IIRDF1_ASSERT(a_out_no_overwrite, out_load |-> (!out_vld_q || m_axis_tready_i),
    "output register loaded while a result is pending")
  `IIRDF1_ASSERT(a_fill_bound, (fill_q >= FILL_ONE) && (fill_q <= FILL_MAX),
    "fill counter out of range")
  `IIRDF1_ASSERT(a_step_bound, (state_q == S_MAC) |-> (step_q <= LAST_STEP),
    "tap step beyond last tap")

endmodule

// ----- sv/iirdf1_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iirdf1_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/iirdf1_output_checker.sv -----
// Result checker for the IIR direct-form-I filter core: follows the coefficient writes
// and the input stream, predicts each output beat and compares it. Needs iirdf1_pkg.
`timescale 1ns / 1ps

module iirdf1_output_checker
  import iirdf1_pkg::*;
#(
  parameter int unsigned ORDER = DEFAULT_ORDER
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [15:0]       s_tdata_i,   // [15:0] sample
  input  logic              s_tuser_i,   // [0] operation
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [23:0]       m_tdata_i,   // [15:0] filtered, [16] saturated,
                                         // [17] history_filled, [23:18] zero
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                errors_o,
  output int                pending_o,
  output int                checked_o,
  output int                clamped_o
);

  localparam int unsigned ACC_FRAC = 20;   // Q.28 sum down to Q.8 history
  localparam int unsigned OUT_FRAC = 8;    // Q.8 history down to integer output
  localparam longint HIST_TOP    = (longint'(1) <<< (HIST_W - 1)) - 1;
  localparam longint HIST_BOTTOM = -(longint'(1) <<< (HIST_W - 1));
  localparam longint OUT_TOP     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_BOTTOM  = -(longint'(1) <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic                       filled;
    logic                       clamped;
    logic signed [SAMPLE_W-1:0] value;
  } filter_out_t;

  logic signed [COEF_W-1:0]   coef   [NUM_COEF];
  logic signed [SAMPLE_W-1:0] x_hist [ORDER];
  logic signed [HIST_W-1:0]   y_hist [ORDER];
  int unsigned                fill;

  filter_out_t filter_out_q [$];
  int          mismatches = 0;
  int          compared   = 0;
  int          clamp_hits = 0;
  int          waiting    = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;
  assign checked_o = compared;
  assign clamped_o = clamp_hits;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 40)
      $display("%0t ns: output beat %0d: %s is %0d, expected %0d",
               $realtime, compared, what, got, want);
    mismatches++;
  endtask

  // One item through the filter: updates the delay lines and the fill count.
  function automatic filter_out_t next_filter_output(input logic op,
                                                     input logic signed [SAMPLE_W-1:0] x);
    filter_out_t res;
    longint      acc;
    longint      y;
    longint      r;
    int          k;
    res = '0;
    if (op == OP_CLEAR) begin
      for (k = 0; k < int'(ORDER); k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      fill = 1;
      res.filled = (fill >= ORDER);
      return res;
    end
    acc = longint'(coef[CIDX_B0]) * longint'(x) * 256;
    for (k = 1; k <= int'(ORDER); k++) begin
      if (k <= int'(COEF_TAPS)) begin
        acc += longint'(coef[CIDX_B0 + k]) * longint'(x_hist[k-1]) * 256;
        acc -= longint'(coef[CIDX_A_BASE + k]) * longint'(y_hist[k-1]);
      end
    end
    y = (acc + (longint'(1) <<< (ACC_FRAC - 1))) >>> ACC_FRAC;
    if (y > HIST_TOP) y = HIST_TOP;
    if (y < HIST_BOTTOM) y = HIST_BOTTOM;
    for (k = int'(ORDER) - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = y[HIST_W-1:0];
    if (fill < ORDER) fill++;
    r = (y + (longint'(1) <<< (OUT_FRAC - 1))) >>> OUT_FRAC;
    if (r > OUT_TOP) begin
      r = OUT_TOP;
      res.clamped = 1'b1;
    end else if (r < OUT_BOTTOM) begin
      r = OUT_BOTTOM;
      res.clamped = 1'b1;
    end
    res.value  = r[SAMPLE_W-1:0];
    res.filled = (fill >= ORDER);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_out_t want;
    filter_out_t got;
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_COEF); i++) coef[i] = COEF_RESET[i];
      for (int i = 0; i < int'(ORDER); i++) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      fill = 1;
      filter_out_q.delete();
      waiting <= 0;
    end else begin
      // Track coefficient writes; indexes past the last register are dropped.
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_AW-1:2] < NUM_COEF)
        coef[paddr_i[APB_AW-1:2]] = pwdata_i[COEF_W-1:0];
      // Pop before push so a beat that nothing explains is caught.
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[17:0];
        if (filter_out_q.size() == 0) begin
          report_mismatch("unexpected result beat, tdata", longint'(m_tdata_i), 0);
        end else begin
          want = filter_out_q.pop_front();
          if (got.value !== want.value)
            report_mismatch("filtered", longint'(got.value), longint'(want.value));
          if (got.clamped !== want.clamped)
            report_mismatch("saturated", longint'(got.clamped), longint'(want.clamped));
          if (got.filled !== want.filled)
            report_mismatch("history_filled", longint'(got.filled), longint'(want.filled));
          if (m_tdata_i[23:18] !== '0)
            report_mismatch("tdata padding", longint'(m_tdata_i[23:18]), 0);
          if (want.clamped) clamp_hits++;
        end
        compared++;
      end
      if (s_tvalid_i && s_tready_i)
        filter_out_q.push_back(next_filter_output(s_tuser_i, s_tdata_i));
      waiting <= filter_out_q.size();
    end
  end

endmodule

// ----- bench/tb_iir_direct_form1_filter_core.sv -----
// Testbench top for the IIR direct-form-I filter core: clock, reset, stream and APB
// stimulus, receiver back-pressure and the verdict. Needs iirdf1_pkg, the core and
// iirdf1_output_checker.
`timescale 1ns / 1ps

module tb_iir_direct_form1_filter_core;
  import iirdf1_pkg::*;

  // Run shape. BEAT_CYCLES is the core's time per filter beat; the drain at the
  // end is measured in it after the last result.
  localparam int unsigned ORDER       = DEFAULT_ORDER;
  localparam int          BEAT_CYCLES = 2 * ((ORDER < COEF_TAPS) ? ORDER : COEF_TAPS) + 5;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_BEATS = 200;
  // Slowest legal run is roughly 1.6k beats, each paying core time, sender gap and
  // receiver stall; allow about five times that.
  localparam int          CYCLE_LIMIT = 400_000;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Families of coefficient sets used by the random phases.
  typedef enum int {
    SET_DEFAULT,   // the low-pass loaded at reset, written back explicitly
    SET_DAMPED,    // random taps with small feedback, so the loop stays stable
    SET_WILD,      // any 24-bit value: mostly blows up and pins the histories
    SET_FIR,       // feedback off, random feed-forward taps
    SET_EXTREME    // each tap at min, max, zero or +-1 LSB
  } coef_set_e;

  // Receiver back-pressure styles, switched at random intervals.
  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_CHOPPY
  } rx_style_e;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       s_axis_tvalid  = 1'b0;
  logic                       s_axis_tready;
  logic signed [SAMPLE_W-1:0] s_axis_tdata   = '0;   // [15:0] sample
  logic                       s_axis_tuser   = 1'b0; // [0] operation
  logic                       m_axis_tvalid;
  logic                       m_axis_tready  = 1'b0;
  logic [23:0]                m_axis_tdata;          // [15:0] filtered, [16] saturated,
                                                     // [17] history_filled
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [APB_AW-1:0]          paddr          = '0;
  logic [31:0]                pwdata         = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int errors;
  int pending;
  int checked;
  int clamped;

  int cycle_count    = 0;
  int beats_sent     = 0;
  int clears_sent    = 0;
  int sets_loaded    = 0;
  int burst_left     = 0;

  rx_style_e rx_style     = RX_OPEN;
  int        rx_style_left = 0;
  int        rx_hold_left  = 0;

  always #1 clk_i = ~clk_i;

  iir_direct_form1_filter_core #(
    .ORDER(ORDER)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready)
  );

  iirdf1_output_checker #(
    .ORDER(ORDER)
  ) u_output_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .pready_i  (pready),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked),
    .clamped_o (clamped)
  );

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("tb_iir_direct_form1_filter_core: errors");
      $finish;
    end
  end

  // Receiver: pick a back-pressure style at random intervals. The choppy style
  // alternates long stalls with short open windows, so the core's output register
  // fills and the write-back stall gets exercised.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_style_left == 0) begin
        rx_style      <= rx_style_e'($urandom_range(0, 2));
        rx_style_left <= $urandom_range(32, 256);
      end else begin
        rx_style_left <= rx_style_left - 1;
      end
      case (rx_style)
        RX_OPEN: begin
          m_axis_tready <= 1'b1;
        end
        RX_RANDOM: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (rx_hold_left == 0) begin
            m_axis_tready <= ~m_axis_tready;
            rx_hold_left  <= m_axis_tready ? $urandom_range(1, 25) : $urandom_range(1, 8);
          end else begin
            rx_hold_left <= rx_hold_left - 1;
          end
        end
      endcase
    end
  end

  function automatic int rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mix of rails, small values near zero and full-range noise.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'(rand_span(300));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Present one beat and hold it until the core takes it. Beats come in bursts
  // of up to 25; between bursts the sender usually idles for a random gap.
  task automatic send_beat(input logic op, input logic signed [SAMPLE_W-1:0] sample);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (op == OP_CLEAR) clears_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and hold until every predicted result has come back. Every beat
  // yields a result, so an empty queue means the core is idle.
  task automatic pause_stream();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Setup cycle, then access cycle; release the bus afterwards.
  task automatic write_coef(input int unsigned idx, input logic signed [COEF_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= {{(32-COEF_W){value[COEF_W-1]}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a full coefficient set of the given family, plus a stray write just past
  // the last register that the core must ignore.
  task automatic load_coef_set(input coef_set_e family);
    logic signed [COEF_W-1:0] c [NUM_COEF];
    int unsigned k;
    for (k = 0; k < NUM_COEF; k++) begin
      case (family)
        SET_DEFAULT: c[k] = COEF_RESET[k];
        SET_DAMPED: begin
          if (k <= CIDX_A_BASE) c[k] = COEF_W'(rand_span(1 << 19));
          else c[k] = COEF_W'(rand_span(1 << (20 - (k - CIDX_A_BASE))));
        end
        SET_WILD: c[k] = COEF_W'($urandom);
        SET_FIR: c[k] = (k <= CIDX_A_BASE) ? COEF_W'(rand_span(1 << 20)) : '0;
        default: begin
          case ($urandom_range(0, 4))
            0:       c[k] = COEF_MAX;
            1:       c[k] = COEF_MIN;
            2:       c[k] = '0;
            3:       c[k] = -1;
            default: c[k] = 1;
          endcase
        end
      endcase
      write_coef(k, c[k]);
    end
    write_coef(NUM_COEF, COEF_W'($urandom));
    sets_loaded++;
  endtask

  initial begin
    int phase;
    int n;
    int run_left;
    logic signed [SAMPLE_W-1:0] run_val;
    run_left = 0;
    run_val  = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset coefficients: a sample straight out of reset, a clear, rails in
    // both directions, values around zero, then a clear and a refill of the history.
    send_beat(OP_FILTER, SAMPLE_MAX);
    send_beat(OP_CLEAR, '0);
    repeat (4) send_beat(OP_FILTER, SAMPLE_MAX);
    repeat (3) send_beat(OP_FILTER, SAMPLE_MIN);
    send_beat(OP_FILTER, '0);
    send_beat(OP_FILTER, 16'sd1);
    send_beat(OP_FILTER, -16'sd1);
    send_beat(OP_CLEAR, SAMPLE_MIN);
    send_beat(OP_FILTER, SAMPLE_MIN);
    send_beat(OP_FILTER, SAMPLE_MAX);
    pause_stream();

    // Directed, extreme coefficients: large gain clamps the output both ways and
    // a1 at its minimum drives the output history into its own saturation.
    write_coef(CIDX_B0, COEF_MAX);
    write_coef(CIDX_B0 + 1, COEF_MIN);
    write_coef(CIDX_B0 + 2, '0);
    write_coef(CIDX_A_BASE, COEF_MAX);
    write_coef(CIDX_A_BASE + 1, COEF_MIN);
    write_coef(CIDX_A_BASE + 2, COEF_MAX);
    write_coef(CIDX_A_BASE + 3, -1);
    write_coef(NUM_COEF, COEF_MIN);
    sets_loaded++;
    send_beat(OP_CLEAR, '0);
    send_beat(OP_FILTER, SAMPLE_MAX);
    send_beat(OP_FILTER, SAMPLE_MIN);
    send_beat(OP_FILTER, 16'sd1);
    send_beat(OP_FILTER, '0);
    send_beat(OP_FILTER, '0);
    send_beat(OP_CLEAR, SAMPLE_MAX);
    send_beat(OP_FILTER, -16'sd1);
    send_beat(OP_FILTER, SAMPLE_MIN);
    pause_stream();

    // Random phases: long runs of filter beats (held steps and noise) so the
    // history fills and settles, with an occasional clear in between.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      load_coef_set(coef_set_e'(phase % 5));
      for (n = 0; n < PHASE_BEATS; n++) begin
        // Hold off mid-phase until the core has drained completely.
        if (n == PHASE_BEATS / 2 && phase % 3 == 1) pause_stream();
        if ($urandom_range(0, 49) == 0) begin
          send_beat(OP_CLEAR, SAMPLE_W'($urandom));
        end else begin
          if (run_left == 0) begin
            run_val  = pick_sample();
            run_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 1;
          end
          run_left--;
          send_beat(OP_FILTER, run_val);
        end
      end
      pause_stream();
    end

    // Give a late or duplicated result time to show up.
    repeat (4 * BEAT_CYCLES) @(posedge clk_i);

    $display("sent %0d beats (%0d clears) across %0d coefficient sets", beats_sent,
             clears_sent, sets_loaded);
    $display("compared %0d results, %0d of them clamped to the 16-bit rails", checked,
             clamped);
    if (errors == 0) begin
      $display("tb_iir_direct_form1_filter_core: clean");
    end else begin
      $display("tb_iir_direct_form1_filter_core: errors");
    end
    $finish;
  end

endmodule
